@@ hw/rtl/btc_pkg.sv @@
// Shared types, register indexes and helper functions for the barometric
// trim compensation block. No dependencies.
package btc_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_TEMP_TRIM    = 2'd0,
    REG_PRESS_TRIM_A = 2'd1,
    REG_PRESS_TRIM_B = 2'd2,
    REG_PRESS_TRIM_C = 2'd3
  } btc_reg_t;

  localparam int unsigned CfgWidth    = 48;
  localparam int unsigned PipeDepth   = 13;
  localparam int unsigned TqDelay     = 8;
  localparam logic signed [63:0] TqMax   = 64'sd32767;
  localparam logic signed [63:0] TqMin   = -64'sd32768;
  localparam logic signed [63:0] TpMax   = 64'sd134217727;
  localparam logic signed [63:0] TpMin   = -64'sd134217728;
  localparam logic signed [63:0] PresMax = 64'sd16777215;

  // Trim fields, unpacked and offset where the polynomial needs it
  typedef struct packed {
    logic        [15:0] t1;
    logic signed [16:0] t2;
    logic signed [7:0]  t3;
    logic signed [16:0] p1m;
    logic signed [16:0] p2m;
    logic signed [7:0]  p3;
    logic signed [7:0]  p4;
    logic signed [16:0] p5;
    logic signed [16:0] p6;
    logic signed [7:0]  p7;
    logic signed [7:0]  p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p10;
    logic signed [7:0]  p11;
  } btc_trim_t;

  // Round half up, then shift right by s (s is always a constant).
  function automatic logic signed [63:0] rnd(input logic signed [63:0] x,
                                             input int unsigned s);
    logic signed [63:0] bias;
    bias = 64'sd1 <<< (s - 1);
    return (x + bias) >>> s;
  endfunction

  // Split the four trim words into their fields.
  function automatic btc_trim_t unpack_trim(input logic [39:0] tt,
                                            input logic [47:0] pa,
                                            input logic [47:0] pb,
                                            input logic [31:0] pc);
    btc_trim_t r;
    r.t1  = tt[15:0];
    r.t2  = $signed({1'b0, tt[31:16]});
    r.t3  = $signed(tt[39:32]);
    r.p1m = 17'($signed(pa[15:0])) - 17'sd16384;
    r.p2m = 17'($signed(pa[31:16])) - 17'sd16384;
    r.p3  = $signed(pa[39:32]);
    r.p4  = $signed(pa[47:40]);
    r.p5  = $signed({1'b0, pb[15:0]});
    r.p6  = $signed({1'b0, pb[31:16]});
    r.p7  = $signed(pb[39:32]);
    r.p8  = $signed(pb[47:40]);
    r.p9  = $signed(pc[15:0]);
    r.p10 = $signed(pc[23:16]);
    r.p11 = $signed(pc[31:24]);
    return r;
  endfunction

endpackage

@@ hw/rtl/btc_temp.sv @@
// Temperature polynomial: pipeline stages one to four.
// Depends on btc_pkg for the trim type and the rounding helper.
module btc_temp (
  input  logic                    clk,
  input  logic                    en,
  input  logic                    in_load,
  input  logic [23:0]             raw_p,
  input  logic [23:0]             raw_t,
  input  btc_pkg::btc_trim_t      trim,
  output logic signed [15:0]      tq4,
  output logic signed [27:0]      tp4,
  output logic                    sat4,
  output logic [23:0]             p4
);

  logic signed [25:0] d1_r, d1_nxt;
  logic [23:0]        p1_r, p2_r, p3_r, p4_r;
  logic signed [41:0] a2_r, a2_nxt;
  logic signed [49:0] dd2_r, dd2_nxt;
  logic signed [60:0] t48_r, t48_nxt;
  logic signed [15:0] tq_r, tq_nxt;
  logic signed [27:0] tp_r, tp_nxt;
  logic               sat_r, sat_nxt;
  logic signed [63:0] tq_w, tp_w;

  // Offset of the raw reading from the trim reference
  always_comb begin
    d1_nxt = $signed({2'b00, raw_t}) - $signed({2'b00, trim.t1, 8'h00});
  end

  // Linear and square terms
  always_comb begin
    a2_nxt  = d1_r * trim.t2;
    dd2_nxt = d1_r * d1_r;
  end

  // Full-precision temperature in 2^-48 degC
  always_comb begin
    t48_nxt = (61'(a2_r) <<< 18) + dd2_r * trim.t3;
  end

  // Output temperature and the clamped pressure-path temperature
  always_comb begin
    tq_w    = btc_pkg::rnd(64'(t48_r), 40);
    tp_w    = btc_pkg::rnd(64'(t48_r), 28);
    sat_nxt = 1'b0;
    tq_nxt  = 16'(tq_w);
    tp_nxt  = 28'(tp_w);
    if (tq_w > btc_pkg::TqMax) begin
      tq_nxt  = 16'(btc_pkg::TqMax);
      sat_nxt = 1'b1;
    end else if (tq_w < btc_pkg::TqMin) begin
      tq_nxt  = 16'(btc_pkg::TqMin);
      sat_nxt = 1'b1;
    end
    if (tp_w > btc_pkg::TpMax) begin
      tp_nxt  = 28'(btc_pkg::TpMax);
      sat_nxt = 1'b1;
    end else if (tp_w < btc_pkg::TpMin) begin
      tp_nxt  = 28'(btc_pkg::TpMin);
      sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_load) begin
        d1_r <= d1_nxt;
        p1_r <= raw_p;
      end
      a2_r  <= a2_nxt;
      dd2_r <= dd2_nxt;
      p2_r  <= p1_r;
      t48_r <= t48_nxt;
      p3_r  <= p2_r;
      tq_r  <= tq_nxt;
      tp_r  <= tp_nxt;
      sat_r <= sat_nxt;
      p4_r  <= p3_r;
    end
  end

  assign tq4  = tq_r;
  assign tp4  = tp_r;
  assign sat4 = sat_r;
  assign p4   = p4_r;

endmodule

@@ hw/rtl/btc_press.sv @@
// Cubic pressure polynomial: pipeline stages five to twelve.
// Depends on btc_pkg for the trim type and the rounding helper.
module btc_press (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [27:0]      tp4,
  input  logic [23:0]             p4,
  input  btc_pkg::btc_trim_t      trim,
  output logic signed [57:0]      tot12
);

  logic signed [24:0] ps6, ps7, ps8, ps10;
  logic [23:0]        p5_r, p6_r, p7_r, p8_r, p9_r, p10_r;
  logic signed [27:0] tp5_r, tp6_r;
  logic signed [55:0] tt5_r, tt5_nxt;
  logic signed [44:0] p6t5_r, p6t5_nxt, p2t5_r, p2t5_nxt;
  logic signed [35:0] p10t5_r, p10t5_nxt;
  logic [47:0]        pp5_r, pp5_nxt;
  logic signed [35:0] ts6_r, ts6_nxt;
  logic signed [33:0] q6_r, q6_nxt;
  logic signed [56:0] ppp6_r, ppp6_nxt;
  logic signed [53:0] o1a6_r, o1a6_nxt, o1a7_r;
  logic signed [39:0] ka6_r, ka6_nxt, ka7_r;
  logic signed [62:0] tsp7_r, tsp7_nxt;
  logic signed [43:0] p7ts7_r, p7ts7_nxt, p3ts7_r, p3ts7_nxt;
  logic signed [57:0] pq7_r, pq7_nxt;
  logic signed [32:0] r4_7_r, r4_7_nxt;
  logic signed [42:0] tc8_r, tc8_nxt;
  logic signed [54:0] o1b8_r, o1b8_nxt, o1b9_r;
  logic signed [39:0] kb8_r, kb8_nxt, kb9_r;
  logic signed [37:0] r3_8_r, r3_8_nxt;
  logic signed [56:0] o4p8_r, o4p8_nxt;
  logic signed [50:0] p8tc9_r, p8tc9_nxt, p4tc9_r, p4tc9_nxt;
  logic signed [62:0] o3p9_r, o3p9_nxt;
  logic signed [48:0] o4_9_r, o4_9_nxt, o4_10_r;
  logic signed [55:0] o1_10_r, o1_10_nxt;
  logic signed [40:0] k10_r, k10_nxt;
  logic signed [50:0] o3_10_r, o3_10_nxt;
  logic signed [63:0] pk11_r, pk11_nxt;
  logic signed [56:0] s11_r, s11_nxt;
  logic signed [57:0] tot12_r, tot12_nxt;

  assign ps6  = $signed({1'b0, p6_r});
  assign ps7  = $signed({1'b0, p7_r});
  assign ps8  = $signed({1'b0, p8_r});
  assign ps10 = $signed({1'b0, p10_r});

  // Stage five: products with the temperature and the pressure square
  always_comb begin
    tt5_nxt   = tp4 * tp4;
    p6t5_nxt  = trim.p6 * tp4;
    p2t5_nxt  = trim.p2m * tp4;
    p10t5_nxt = trim.p10 * tp4;
    pp5_nxt   = p4 * p4;
  end

  // Stage six: temperature square, quadratic coefficient, first partial sums
  always_comb begin
    ts6_nxt  = 36'(btc_pkg::rnd(64'(tt5_r), 20));
    q6_nxt   = (34'(trim.p9) <<< 16) + 34'(btc_pkg::rnd(64'(p10t5_r), 4));
    ppp6_nxt = $signed({1'b0, pp5_r}) * trim.p11;
    o1a6_nxt = (54'(trim.p5) <<< 35) + (54'(p6t5_r) <<< 6);
    ka6_nxt  = (40'(trim.p1m) <<< 20) + 40'(btc_pkg::rnd(64'(p2t5_r), 9));
  end

  // Stage seven: products with the temperature square
  always_comb begin
    tsp7_nxt  = ts6_r * tp6_r;
    p7ts7_nxt = trim.p7 * ts6_r;
    p3ts7_nxt = trim.p3 * ts6_r;
    pq7_nxt   = ps6 * q6_r;
    r4_7_nxt  = 33'(btc_pkg::rnd(64'(ppp6_r), 25));
  end

  // Stage eight: temperature cube and further partial sums
  always_comb begin
    tc8_nxt  = 43'(btc_pkg::rnd(64'(tsp7_r), 20));
    o1b8_nxt = 55'(o1a7_r) + (55'(p7ts7_r) <<< 4);
    kb8_nxt  = ka7_r + 40'(btc_pkg::rnd(64'(p3ts7_r), 12));
    r3_8_nxt = 38'(btc_pkg::rnd(64'(pq7_r), 20));
    o4p8_nxt = r4_7_r * ps7;
  end

  // Stage nine: products with the temperature cube and the pressure
  always_comb begin
    p8tc9_nxt = trim.p8 * tc8_r;
    p4tc9_nxt = trim.p4 * tc8_r;
    o3p9_nxt  = r3_8_r * ps8;
    o4_9_nxt  = 49'(btc_pkg::rnd(64'(o4p8_r), 8));
  end

  // Stage ten: close the offset and sensitivity sums
  always_comb begin
    o1_10_nxt = 56'(o1b9_r) + 56'(btc_pkg::rnd(64'(p8tc9_r), 3));
    k10_nxt   = 41'(kb9_r) + 41'(btc_pkg::rnd(64'(p4tc9_r), 17));
    o3_10_nxt = 51'(btc_pkg::rnd(64'(o3p9_r), 12));
  end

  // Stage eleven: sensitivity times pressure, sum of the other terms
  always_comb begin
    pk11_nxt = ps10 * k10_r;
    s11_nxt  = 57'(o1_10_r) + 57'(o3_10_r) + 57'(o4_10_r);
  end

  // Stage twelve: total in 2^-32 Pa
  always_comb begin
    tot12_nxt = 58'(btc_pkg::rnd(pk11_r, 8)) + 58'(s11_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tt5_r   <= tt5_nxt;
      p6t5_r  <= p6t5_nxt;
      p2t5_r  <= p2t5_nxt;
      p10t5_r <= p10t5_nxt;
      pp5_r   <= pp5_nxt;
      tp5_r   <= tp4;
      p5_r    <= p4;
      ts6_r   <= ts6_nxt;
      q6_r    <= q6_nxt;
      ppp6_r  <= ppp6_nxt;
      o1a6_r  <= o1a6_nxt;
      ka6_r   <= ka6_nxt;
      tp6_r   <= tp5_r;
      p6_r    <= p5_r;
      tsp7_r  <= tsp7_nxt;
      p7ts7_r <= p7ts7_nxt;
      p3ts7_r <= p3ts7_nxt;
      pq7_r   <= pq7_nxt;
      r4_7_r  <= r4_7_nxt;
      o1a7_r  <= o1a6_r;
      ka7_r   <= ka6_r;
      p7_r    <= p6_r;
      tc8_r   <= tc8_nxt;
      o1b8_r  <= o1b8_nxt;
      kb8_r   <= kb8_nxt;
      r3_8_r  <= r3_8_nxt;
      o4p8_r  <= o4p8_nxt;
      p8_r    <= p7_r;
      p8tc9_r <= p8tc9_nxt;
      p4tc9_r <= p4tc9_nxt;
      o3p9_r  <= o3p9_nxt;
      o4_9_r  <= o4_9_nxt;
      o1b9_r  <= o1b8_r;
      kb9_r   <= kb8_r;
      p9_r    <= p8_r;
      o1_10_r <= o1_10_nxt;
      k10_r   <= k10_nxt;
      o3_10_r <= o3_10_nxt;
      o4_10_r <= o4_9_r;
      p10_r   <= p9_r;
      pk11_r  <= pk11_nxt;
      s11_r   <= s11_nxt;
      tot12_r <= tot12_nxt;
    end
  end

  assign tot12 = tot12_r;

endmodule

@@ hw/rtl/barometric_trim_compensation.sv @@
// Top level of the barometric trim compensation block.
// Depends on btc_pkg, btc_temp and btc_press.
//
// Usage: each input request carries one raw pressure and one raw temperature
// reading; each output request carries the compensated temperature
// (1/256 degC), the compensated pressure (1/64 Pa) and a saturation flag.
// The four trim words are written through the cfg_ port, one register per
// write, while no reading is in flight.
// The block is a 13-stage pipeline: each accepted request raises out_tvalid
// when it leaves the last stage, and its result can then be taken there. It
// accepts one reading per cycle while no result is held by the receiver;
// throughput is one result per cycle, set by the pipeline's common advance signal.
// Reset clears the trim registers to zero and empties the pipeline.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_tready falls in the same cycle; nothing is lost or repeated.
module barometric_trim_compensation (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [23:0] raw_pressure, [47:24] raw_temperature
  input  logic [47:0]                       in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] temp_fixed, [39:16] pressure_fixed
  output logic [39:0]                       out_tdata,
  // [0] saturated
  output logic                              out_tuser,
  input  logic                              cfg_wr_en,
  input  logic [1:0]                        cfg_index,
  input  logic [btc_pkg::CfgWidth-1:0]      cfg_wdata
);

  logic [39:0] temp_trim_r;
  logic [47:0] press_trim_a_r, press_trim_b_r;
  logic [31:0] press_trim_c_r;
  btc_pkg::btc_trim_t trim;

  logic                               en;
  logic [btc_pkg::PipeDepth-1:0]      vld_r, vld_nxt;
  logic signed [15:0]                 tq4;
  logic signed [27:0]                 tp4;
  logic                               sat4;
  logic [23:0]                        p4;
  logic signed [57:0]                 tot12;
  logic signed [15:0]                 tq_dly_r [btc_pkg::TqDelay];
  logic                               sat_dly_r [btc_pkg::TqDelay];
  logic signed [15:0]                 tq_r;
  logic [23:0]                        pr_r, pr_nxt;
  logic                               sat_r, sat_nxt;
  logic signed [63:0]                 pr_w;

  // Trim registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_trim_r    <= '0;
      press_trim_a_r <= '0;
      press_trim_b_r <= '0;
      press_trim_c_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (btc_pkg::btc_reg_t'(cfg_index))
        btc_pkg::REG_TEMP_TRIM:    temp_trim_r    <= cfg_wdata[39:0];
        btc_pkg::REG_PRESS_TRIM_A: press_trim_a_r <= cfg_wdata[47:0];
        btc_pkg::REG_PRESS_TRIM_B: press_trim_b_r <= cfg_wdata[47:0];
        btc_pkg::REG_PRESS_TRIM_C: press_trim_c_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  assign trim = btc_pkg::unpack_trim(temp_trim_r, press_trim_a_r,
                                     press_trim_b_r, press_trim_c_r);

  // The pipeline advances unless a finished result is held by the receiver.
  assign en        = !vld_r[btc_pkg::PipeDepth-1] || out_tready;
  assign in_tready = en;

  always_comb begin
    vld_nxt = {vld_r[btc_pkg::PipeDepth-2:0], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  btc_temp u_temp (
    .clk     (clk),
    .en      (en),
    .in_load (in_tvalid),
    .raw_p   (in_tdata[23:0]),
    .raw_t   (in_tdata[47:24]),
    .trim    (trim),
    .tq4     (tq4),
    .tp4     (tp4),
    .sat4    (sat4),
    .p4      (p4)
  );

  btc_press u_press (
    .clk   (clk),
    .en    (en),
    .tp4   (tp4),
    .p4    (p4),
    .trim  (trim),
    .tot12 (tot12)
  );

  // Carry temperature and its flag alongside the pressure stages
  always_ff @(posedge clk) begin
    if (en) begin
      tq_dly_r[0]  <= tq4;
      sat_dly_r[0] <= sat4;
      for (int i = 1; i < btc_pkg::TqDelay; i++) begin
        tq_dly_r[i]  <= tq_dly_r[i-1];
        sat_dly_r[i] <= sat_dly_r[i-1];
      end
    end
  end

  // Final rounding and clipping of the pressure
  always_comb begin
    pr_w    = btc_pkg::rnd(64'(tot12), 26);
    pr_nxt  = 24'(pr_w);
    sat_nxt = sat_dly_r[btc_pkg::TqDelay-1];
    if (pr_w > btc_pkg::PresMax) begin
      pr_nxt  = 24'(btc_pkg::PresMax);
      sat_nxt = 1'b1;
    end else if (pr_w < 64'sd0) begin
      pr_nxt  = '0;
      sat_nxt = 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      tq_r  <= tq_dly_r[btc_pkg::TqDelay-1];
      pr_r  <= pr_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_tvalid = vld_r[btc_pkg::PipeDepth-1];
  assign out_tdata  = {pr_r, tq_r};
  assign out_tuser  = sat_r;

endmodule

@@ hw/rtl/btc_checker.sv @@
// Port-level checks for barometric_trim_compensation, bound to the top level.
// Depends on btc_pkg for the configuration width.
module btc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic [47:0]                  in_tdata,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [39:0]                  out_tdata,
  input logic                         out_tuser,
  input logic                         cfg_wr_en,
  input logic [1:0]                   cfg_index,
  input logic [btc_pkg::CfgWidth-1:0] cfg_wdata
);

  // A reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
                                  && $stable(out_tuser))
    else $error("stalled result changed");

  // The input side takes requests exactly when the pipeline can advance.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  // A waiting request keeps its contents until it is accepted.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("waiting request changed");

  // Trim writes arrive with known values while no result is waiting.
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |-> !out_tvalid && !$isunknown({cfg_index, cfg_wdata}))
    else $error("trim write while a result is waiting");

endmodule

bind barometric_trim_compensation btc_checker u_btc_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for the barometric trim compensation block.
// Depends on btc_pkg and the barometric_trim_compensation top level.
`timescale 1ns / 1ps

// Keeps the trim words and the queue of expected compensated readings.
class btc_scoreboard;
  typedef struct {
    logic [15:0] temp_fixed;
    logic [23:0] pressure_fixed;
    logic        saturated;
  } reading_t;

  logic [39:0] temp_trim;
  logic [47:0] press_trim_a;
  logic [47:0] press_trim_b;
  logic [31:0] press_trim_c;
  reading_t    pending[$];
  int          errors;

  function new();
    temp_trim = '0;
    press_trim_a = '0;
    press_trim_b = '0;
    press_trim_c = '0;
    errors = 0;
  endfunction

  // Updates the shadow copy of one trim register.
  function void write_trim(btc_pkg::btc_reg_t idx, logic [47:0] val);
    case (idx)
      btc_pkg::REG_TEMP_TRIM:    temp_trim = val[39:0];
      btc_pkg::REG_PRESS_TRIM_A: press_trim_a = val;
      btc_pkg::REG_PRESS_TRIM_B: press_trim_b = val;
      default:                   press_trim_c = val[31:0];
    endcase
  endfunction

  // Round half up and shift right.
  function longint half_up(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // Computes the compensated reading for one accepted request.
  function void note_reading(logic [23:0] raw_p, logic [23:0] raw_t);
    longint pr, tt, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    longint d, t48, tq, tp, ts, tc, o1, k, o2, q, o3, o4, sum;
    reading_t r;
    pr = longint'(raw_p);
    tt = longint'(raw_t);
    t1 = longint'(temp_trim[15:0]);
    t2 = longint'(temp_trim[31:16]);
    t3 = longint'($signed(temp_trim[39:32]));
    p1 = longint'($signed(press_trim_a[15:0]));
    p2 = longint'($signed(press_trim_a[31:16]));
    p3 = longint'($signed(press_trim_a[39:32]));
    p4 = longint'($signed(press_trim_a[47:40]));
    p5 = longint'(press_trim_b[15:0]);
    p6 = longint'(press_trim_b[31:16]);
    p7 = longint'($signed(press_trim_b[39:32]));
    p8 = longint'($signed(press_trim_b[47:40]));
    p9 = longint'($signed(press_trim_c[15:0]));
    p10 = longint'($signed(press_trim_c[23:16]));
    p11 = longint'($signed(press_trim_c[31:24]));
    r.saturated = 1'b0;
    d = tt - t1 * 256;
    t48 = d * t2 * 262144 + d * d * t3;
    tq = half_up(t48, 40);
    if (tq > 32767) begin
      tq = 32767;
      r.saturated = 1'b1;
    end
    if (tq < -32768) begin
      tq = -32768;
      r.saturated = 1'b1;
    end
    tp = half_up(t48, 28);
    if (tp > 134217727) begin
      tp = 134217727;
      r.saturated = 1'b1;
    end
    if (tp < -134217728) begin
      tp = -134217728;
      r.saturated = 1'b1;
    end
    ts = half_up(tp * tp, 20);
    tc = half_up(ts * tp, 20);
    o1 = p5 * (64'sd1 <<< 35) + p6 * tp * 64 + p7 * ts * 16 + half_up(p8 * tc, 3);
    k = (p1 - 16384) * (64'sd1 <<< 20) + half_up((p2 - 16384) * tp, 9)
        + half_up(p3 * ts, 12) + half_up(p4 * tc, 17);
    o2 = half_up(pr * k, 8);
    q = p9 * 65536 + half_up(p10 * tp, 4);
    o3 = half_up(half_up(pr * q, 20) * pr, 12);
    o4 = half_up(half_up(pr * pr * p11, 25) * pr, 8);
    sum = half_up(o1 + o2 + o3 + o4, 26);
    if (sum > 16777215) begin
      sum = 16777215;
      r.saturated = 1'b1;
    end
    if (sum < 0) begin
      sum = 0;
      r.saturated = 1'b1;
    end
    r.temp_fixed = tq[15:0];
    r.pressure_fixed = sum[23:0];
    pending.push_back(r);
  endfunction

  // Compares one accepted result with the oldest expected reading.
  function void check_reading(logic [39:0] data, logic flag);
    reading_t r;
    if (pending.size() == 0) begin
      $error("unexpected result %h", data);
      errors++;
      return;
    end
    r = pending.pop_front();
    if (data[15:0] !== r.temp_fixed) begin
      $error("temp_fixed expected %h actual %h", r.temp_fixed, data[15:0]);
      errors++;
    end
    if (data[39:16] !== r.pressure_fixed) begin
      $error("pressure_fixed expected %h actual %h", r.pressure_fixed, data[39:16]);
      errors++;
    end
    if (flag !== r.saturated) begin
      $error("saturated expected %b actual %b", r.saturated, flag);
      errors++;
    end
  endfunction
endclass

module tb_top;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [47:0] cfg_wdata;

  btc_scoreboard sb;
  int  send_idle;
  int  stall_pct;
  bit  hold_off;
  longint cycles;

  barometric_trim_compensation i_dut (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Run guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: sample at the rising edge, stall at the falling edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_reading(out_tdata, out_tuser);
  end

  always @(negedge clk) begin
    out_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  task automatic write_trim(btc_pkg::btc_reg_t idx, logic [47:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_trim(idx, val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Offers one request and waits for it to be accepted. The valid line stays
  // up on return; the next request or the drain sets it in the same step.
  task automatic send_reading(logic [23:0] p, logic [23:0] t);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {t, p};
    do @(posedge clk); while (!in_tready);
    sb.note_reading(p, t);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (btc_pkg::PipeDepth + 4) @(negedge clk);
  endtask

  // Typical trim set around the sensor's usual working point.
  task automatic typical_trims();
    write_trim(btc_pkg::REG_TEMP_TRIM, 48'({8'hF9, 16'd18500, 16'd27500}));
    write_trim(btc_pkg::REG_PRESS_TRIM_A, {8'hFE, 8'h03, 16'h0010, 16'hF000});
    write_trim(btc_pkg::REG_PRESS_TRIM_B, {8'hFB, 8'h04, 16'd24000, 16'd24000});
    write_trim(btc_pkg::REG_PRESS_TRIM_C, 48'({8'hF0, 8'h10, 16'h1400}));
  endtask

  task automatic random_trims();
    for (int i = 0; i < 4; i++)
      write_trim(btc_pkg::btc_reg_t'(i), 48'({$urandom(), $urandom()}));
  endtask

  task automatic random_batch(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) != 0)
        send_reading(24'($urandom_range(24'h7FFFFF, 24'h4FFFFF)),
                     24'($urandom_range(24'h8FFFFF, 24'h6FFFFF)));
      else
        send_reading(24'($urandom()), 24'($urandom()));
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = btc_pkg::REG_TEMP_TRIM;
    cfg_wdata = '0;
    send_idle = 0;
    stall_pct = 0;
    hold_off = 1'b0;
    cycles = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: all-zero trims, then typical, all-ones and extreme trims.
    send_reading(24'h000000, 24'h000000);
    send_reading(24'hFFFFFF, 24'hFFFFFF);
    drain();
    typical_trims();
    send_reading(24'h6B0000, 24'h7E0000);
    send_reading(24'h000000, 24'h000000);
    send_reading(24'hFFFFFF, 24'hFFFFFF);
    send_reading(24'hFFFFFF, 24'h000000);
    send_reading(24'h000000, 24'hFFFFFF);
    send_reading(24'h555555, 24'hAAAAAA);
    drain();
    for (int i = 0; i < 4; i++)
      write_trim(btc_pkg::btc_reg_t'(i), '1);
    send_reading(24'hFFFFFF, 24'hFFFFFF);
    send_reading(24'h800000, 24'h000000);
    send_reading(24'h000000, 24'h800000);
    drain();
    write_trim(btc_pkg::REG_TEMP_TRIM, 48'({8'h7F, 16'hFFFF, 16'h0000}));
    write_trim(btc_pkg::REG_PRESS_TRIM_A, {8'h80, 8'h7F, 16'h8000, 16'h7FFF});
    write_trim(btc_pkg::REG_PRESS_TRIM_B, {8'h80, 8'h7F, 16'hFFFF, 16'h0000});
    write_trim(btc_pkg::REG_PRESS_TRIM_C, 48'({8'h7F, 8'h80, 16'h8000}));
    send_reading(24'hFFFFFF, 24'hFFFFFF);
    send_reading(24'h123456, 24'h000001);
    drain();

    // Random phases with varying idle patterns and trim sets.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; stall_pct = 0; end
        1: begin send_idle = 68; stall_pct = 0; end
        2: begin send_idle = 0; stall_pct = 68; end
        default: begin send_idle = 11; stall_pct = 11; end
      endcase
      if (ph % 2 == 0) typical_trims();
      else random_trims();
      random_batch(230);
      drain();
    end

    // Long receiver hold-off while requests keep coming.
    send_idle = 0;
    stall_pct = 0;
    typical_trims();
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(negedge clk);
        hold_off = 1'b0;
      end
      random_batch(100);
    join
    drain();
    random_batch(60);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/btc_pkg.sv
hw/rtl/btc_temp.sv
hw/rtl/btc_press.sv
hw/rtl/barometric_trim_compensation.sv
hw/rtl/btc_checker.sv
tb/tb_top.sv
